[hdl/assert_macros.svh]
// assertion macros used by the rtd converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RTD_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtd assertion failed");

// next-cycle implication
`define RTD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtd assertion failed");

`endif

[hdl/rtdtc_pkg.sv]
// types, codes and the pt1000 table of the rtd temperature converter
package rtdtc_pkg;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_REF_RANGE = 3'd1,
      ST_ADC_LOW   = 3'd2,
      ST_ADC_HIGH  = 3'd3,
      ST_DIV_MODE  = 3'd4,
      ST_UNDER     = 3'd5,
      ST_OVER      = 3'd6,
      ST_CONV_MODE = 3'd7
   } status_type;

   localparam logic [1:0] DIV_PULL_DOWN = 2'd0;
   localparam logic [1:0] DIV_PULL_UP   = 2'd1;
   localparam logic [1:0] CONV_TABLE    = 2'd0;
   localparam logic [1:0] CONV_LINEAR   = 2'd1;

   localparam logic [2:0] REG_REF_OHMS  = 3'd0;
   localparam logic [2:0] REG_DIV_MODE  = 3'd1;
   localparam logic [2:0] REG_CONV_MODE = 3'd2;
   localparam logic [2:0] REG_REF_MIN   = 3'd3;
   localparam logic [2:0] REG_REF_MAX   = 3'd4;
   localparam logic [2:0] REG_SENS_MIN  = 3'd5;
   localparam logic [2:0] REG_SENS_MAX  = 3'd6;

   // resistance in 1/16 ohm, saturated; anything above 16*65535 is over range anyway
   localparam int R_W = 21;
   localparam logic [R_W-1:0] R_ZERO_C = 21'd16000;
   localparam logic [14:0] LIN_MAG_MAX = 15'd24000;
   localparam logic [7:0] LIN_SCALE = 8'd250;
   localparam logic [6:0] LIN_ROUND = 7'd76;
   localparam logic [10:0] LIN_DIV = 11'd152;

   localparam logic signed [15:0] ERR_TEMP = -16'sd1000;
   localparam logic signed [15:0] TEMP_MAX = 16'sd32767;

   localparam int TABLE_POINTS = 20;
   localparam int IDX_W = $clog2(TABLE_POINTS + 1);
   localparam int TAB_IDX_W = $clog2(TABLE_POINTS);

   localparam logic [10:0] TAB_OHMS [TABLE_POINTS] = '{
      11'd924, 11'd962, 11'd1000, 11'd1038, 11'd1076, 11'd1095, 11'd1114, 11'd1152,
      11'd1190, 11'd1228, 11'd1266, 11'd1304, 11'd1342, 11'd1380, 11'd1419, 11'd1457,
      11'd1495, 11'd1533, 11'd1571, 11'd1609};
   localparam logic signed [15:0] TAB_CENTI [TABLE_POINTS] = '{
      -16'sd2000, -16'sd1000, 16'sd0, 16'sd1000, 16'sd2000, 16'sd2500, 16'sd3000,
      16'sd4000, 16'sd5000, 16'sd6000, 16'sd7000, 16'sd8000, 16'sd9000, 16'sd10000,
      16'sd11000, 16'sd12000, 16'sd13000, 16'sd14000, 16'sd15000, 16'sd16000};

   // second divider: numerator, divisor and quotient widths
   localparam int N2_W = 23;
   localparam int D2_W = 11;
   localparam int Q2_W = 16;

   typedef struct packed {
      status_type        status;
      logic              direct;
      logic              lin;
      logic              neg;
      logic signed [15:0] base;
   } side_type;

endpackage

[hdl/rtdtc_div.sv]
// pipelined restoring divider, one quotient bit per stage, sideband carried along
module rtdtc_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 12,
   parameter int QUO_W = 32,
   parameter int SB_W  = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic [SB_W-1:0]  out_sb
);

   // numerator must be below den << QUO_W for the quotient to fit
   logic             valid_ff [QUO_W];
   logic [DEN_W-1:0] rem_ff   [QUO_W];
   logic [QUO_W-1:0] bits_ff  [QUO_W];
   logic [DEN_W-1:0] den_ff   [QUO_W];
   logic [SB_W-1:0]  sb_ff    [QUO_W];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         logic             valid_in;
         logic [DEN_W-1:0] rem_in;
         logic [QUO_W-1:0] bits_in;
         logic [DEN_W-1:0] den_in;
         logic [SB_W-1:0]  sb_in;
         logic [DEN_W:0]   trial;
         logic [DEN_W:0]   diff;
         logic             ge;

         if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = DEN_W'(in_num[NUM_W-1:QUO_W]);
            assign bits_in  = in_num[QUO_W-1:0];
            assign den_in   = in_den;
            assign sb_in    = in_sb;
         end else begin : g_next
            assign valid_in = valid_ff[k-1];
            assign rem_in   = rem_ff[k-1];
            assign bits_in  = bits_ff[k-1];
            assign den_in   = den_ff[k-1];
            assign sb_in    = sb_ff[k-1];
         end

         assign trial = {rem_in, bits_in[QUO_W-1]};
         assign diff  = trial - {1'b0, den_in};
         assign ge    = (trial >= {1'b0, den_in});

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= valid_in;
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            bits_ff[k] <= {bits_in[QUO_W-2:0], ge};
            den_ff[k]  <= den_in;
            sb_ff[k]   <= sb_in;
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = bits_ff[QUO_W-1];
   assign out_sb    = sb_ff[QUO_W-1];

endmodule

[hdl/rtd_divider_temperature_convert.sv]
// pt1000 divider reading to temperature, fully pipelined
// path from accepted word to rsp_valid: stage a, the bit-per-stage resistance divider,
// stages b and c, the 16-stage interpolation divider and the stage d output register
// throughput: one word per cycle, busy is low except while reset is high
// reset: synchronous active high, clears the pipeline valids and loads register defaults
// results come out with a one-cycle rsp_valid strobe and cannot be held off
module rtd_divider_temperature_convert #(
   parameter int ADC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ADC_BITS-1:0]  req_adc_raw,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_temperature_centi,
   output logic [2:0]           rsp_status,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata
);

   `include "assert_macros.svh"

   localparam logic [ADC_BITS-1:0] ADC_FS = {ADC_BITS{1'b1}};
   localparam logic [ADC_BITS-1:0] ADC_LOW_LIM = ADC_BITS'(10);
   localparam logic [ADC_BITS-1:0] ADC_HIGH_LIM = ADC_FS - ADC_BITS'(10);
   localparam int PROD_W = 16 + ADC_BITS;
   localparam int Q1_W = PROD_W + 4;
   localparam int R_W = rtdtc_pkg::R_W;
   localparam int SB2_W = $bits(rtdtc_pkg::side_type);

   // configuration registers
   logic [15:0] ref_ohms_ff, ref_min_ff, ref_max_ff, sens_min_ff, sens_max_ff;
   logic [1:0]  div_mode_ff, conv_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ohms_ff  <= 16'd1000;
         div_mode_ff  <= rtdtc_pkg::DIV_PULL_DOWN;
         conv_mode_ff <= rtdtc_pkg::CONV_TABLE;
         ref_min_ff   <= 16'd100;
         ref_max_ff   <= 16'd65535;
         sens_min_ff  <= 16'd800;
         sens_max_ff  <= 16'd1700;
      end else if (csr_we) begin
         case (csr_index)
            rtdtc_pkg::REG_REF_OHMS:  ref_ohms_ff  <= csr_wdata;
            rtdtc_pkg::REG_DIV_MODE:  div_mode_ff  <= csr_wdata[1:0];
            rtdtc_pkg::REG_CONV_MODE: conv_mode_ff <= csr_wdata[1:0];
            rtdtc_pkg::REG_REF_MIN:   ref_min_ff   <= csr_wdata;
            rtdtc_pkg::REG_REF_MAX:   ref_max_ff   <= csr_wdata;
            rtdtc_pkg::REG_SENS_MIN:  sens_min_ff  <= csr_wdata;
            rtdtc_pkg::REG_SENS_MAX:  sens_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // every cycle outside reset is open for a new word
   assign busy = reset;

   // ---------------------------------------------------------------
   // stage a: front checks, pick divider legs, ref * leg product
   // ---------------------------------------------------------------
   logic                  accept;
   rtdtc_pkg::status_type status_a_in;
   logic [ADC_BITS-1:0]   leg_num, leg_den;

   logic                  valid_a_ff;
   rtdtc_pkg::status_type status_a_ff;
   logic [PROD_W-1:0]     prod_a_ff;
   logic [ADC_BITS-1:0]   den_a_ff;

   assign accept = start && !busy;

   always_comb begin
      status_a_in = rtdtc_pkg::ST_OK;
      if (ref_ohms_ff < ref_min_ff || ref_ohms_ff > ref_max_ff) begin
         status_a_in = rtdtc_pkg::ST_REF_RANGE;
      end else if (div_mode_ff == rtdtc_pkg::DIV_PULL_DOWN) begin
         if (req_adc_raw <= ADC_LOW_LIM) status_a_in = rtdtc_pkg::ST_ADC_LOW;
      end else if (div_mode_ff == rtdtc_pkg::DIV_PULL_UP) begin
         if (req_adc_raw >= ADC_HIGH_LIM) status_a_in = rtdtc_pkg::ST_ADC_HIGH;
      end else begin
         status_a_in = rtdtc_pkg::ST_DIV_MODE;
      end
      // pull-down: R = ref*(fs-adc)/adc, pull-up: R = ref*adc/(fs-adc)
      if (div_mode_ff == rtdtc_pkg::DIV_PULL_DOWN) begin
         leg_num = ADC_FS - req_adc_raw;
         leg_den = req_adc_raw;
      end else begin
         leg_num = req_adc_raw;
         leg_den = ADC_FS - req_adc_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_a_ff <= status_a_in;
      prod_a_ff   <= PROD_W'(ref_ohms_ff) * PROD_W'(leg_num);
      den_a_ff    <= leg_den;
   end

   // ---------------------------------------------------------------
   // resistance divider, R16 = 16*ref*leg / den
   // ---------------------------------------------------------------
   logic             valid_q1;
   logic [Q1_W-1:0]  quo_q1;
   logic [2:0]       sb_q1;

   rtdtc_div #(
      .NUM_W (Q1_W + 1),
      .DEN_W (ADC_BITS),
      .QUO_W (Q1_W),
      .SB_W  (3)
   ) u_res_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_a_ff),
      .in_num    ({1'b0, prod_a_ff, 4'b0000}),
      .in_den    (den_a_ff),
      .in_sb     (status_a_ff),
      .out_valid (valid_q1),
      .out_quo   (quo_q1),
      .out_sb    (sb_q1)
   );

   // ---------------------------------------------------------------
   // stage b: limits, table segment search, linear magnitude
   // ---------------------------------------------------------------
   logic [R_W-1:0]                r_sat;
   rtdtc_pkg::status_type         status_b_in;
   logic [rtdtc_pkg::IDX_W-1:0]   idx_b_in;
   logic [R_W:0]                  lin_diff;
   logic                          neg_b_in;
   logic [14:0]                   mag_b_in;

   logic                          valid_b_ff;
   rtdtc_pkg::status_type         status_b_ff;
   logic [R_W-1:0]                r_b_ff;
   logic [rtdtc_pkg::IDX_W-1:0]   idx_b_ff;
   logic                          neg_b_ff;
   logic [14:0]                   mag_b_ff;

   always_comb begin
      r_sat = (|quo_q1[Q1_W-1:R_W]) ? {R_W{1'b1}} : quo_q1[R_W-1:0];

      status_b_in = rtdtc_pkg::status_type'(sb_q1);
      if (status_b_in == rtdtc_pkg::ST_OK) begin
         if (r_sat < R_W'({sens_min_ff, 4'b0000})) begin
            status_b_in = rtdtc_pkg::ST_UNDER;
         end else if (r_sat > R_W'({sens_max_ff, 4'b0000})) begin
            status_b_in = rtdtc_pkg::ST_OVER;
         end else if (conv_mode_ff != rtdtc_pkg::CONV_TABLE &&
                      conv_mode_ff != rtdtc_pkg::CONV_LINEAR) begin
            status_b_in = rtdtc_pkg::ST_CONV_MODE;
         end
      end

      // count of table points at or below R = index of first point above R
      idx_b_in = '0;
      for (int j = 0; j < rtdtc_pkg::TABLE_POINTS; j++) begin
         if (r_sat >= R_W'({rtdtc_pkg::TAB_OHMS[j], 4'b0000})) begin
            idx_b_in = rtdtc_pkg::IDX_W'(j + 1);
         end
      end

      neg_b_in = (r_sat < rtdtc_pkg::R_ZERO_C);
      if (neg_b_in) begin
         lin_diff = {1'b0, rtdtc_pkg::R_ZERO_C - r_sat};
      end else begin
         lin_diff = {1'b0, r_sat - rtdtc_pkg::R_ZERO_C};
      end
      // anything past this magnitude saturates high anyway
      if (lin_diff > (R_W + 1)'(rtdtc_pkg::LIN_MAG_MAX)) begin
         mag_b_in = rtdtc_pkg::LIN_MAG_MAX;
      end else begin
         mag_b_in = lin_diff[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_q1;
      end
   end

   always_ff @(posedge clock) begin
      status_b_ff <= status_b_in;
      r_b_ff      <= r_sat;
      idx_b_ff    <= idx_b_in;
      neg_b_ff    <= neg_b_in;
      mag_b_ff    <= mag_b_in;
   end

   // ---------------------------------------------------------------
   // stage c: interpolation or line numerator and divisor
   // ---------------------------------------------------------------
   logic [rtdtc_pkg::TAB_IDX_W-1:0] seg_lo, seg_hi;
   logic [10:0]                     lo_ohms, hi_ohms;
   logic signed [15:0]              lo_centi, hi_centi;
   logic [R_W-1:0]                  off_full;
   logic [9:0]                      off;
   logic [9:0]                      dt;
   logic [9:0]                      den16;
   logic [rtdtc_pkg::N2_W-1:0]      tab_num, lin_num;
   rtdtc_pkg::side_type             side_c_in;
   logic [rtdtc_pkg::N2_W-1:0]      num_c_in;
   logic [rtdtc_pkg::D2_W-1:0]      den_c_in;

   logic                            valid_c_ff;
   rtdtc_pkg::side_type             side_c_ff;
   logic [rtdtc_pkg::N2_W-1:0]      num_c_ff;
   logic [rtdtc_pkg::D2_W-1:0]      den_c_ff;

   always_comb begin
      // segment between entry idx-1 and idx, only used when inside the table
      seg_hi = (idx_b_ff == rtdtc_pkg::IDX_W'(rtdtc_pkg::TABLE_POINTS) || idx_b_ff == '0)
               ? rtdtc_pkg::TAB_IDX_W'(1) : idx_b_ff[rtdtc_pkg::TAB_IDX_W-1:0];
      seg_lo = seg_hi - rtdtc_pkg::TAB_IDX_W'(1);
      lo_ohms  = rtdtc_pkg::TAB_OHMS[seg_lo];
      hi_ohms  = rtdtc_pkg::TAB_OHMS[seg_hi];
      lo_centi = rtdtc_pkg::TAB_CENTI[seg_lo];
      hi_centi = rtdtc_pkg::TAB_CENTI[seg_hi];

      off_full = r_b_ff - R_W'({lo_ohms, 4'b0000});
      off      = off_full[9:0];
      dt       = 10'(hi_centi - lo_centi);
      den16    = {6'(hi_ohms - lo_ohms), 4'b0000};

      // rounding to nearest: (2*num + den) / (2*den)
      tab_num = rtdtc_pkg::N2_W'({20'(dt) * 20'(off), 1'b0}) + rtdtc_pkg::N2_W'(den16);
      lin_num = rtdtc_pkg::N2_W'(mag_b_ff) * rtdtc_pkg::N2_W'(rtdtc_pkg::LIN_SCALE)
                + rtdtc_pkg::N2_W'(rtdtc_pkg::LIN_ROUND);

      side_c_in.status = status_b_ff;
      side_c_in.neg    = neg_b_ff;
      side_c_in.lin    = (conv_mode_ff == rtdtc_pkg::CONV_LINEAR);
      if (idx_b_ff == '0) begin
         side_c_in.direct = 1'b1;
         side_c_in.base   = rtdtc_pkg::TAB_CENTI[0];
      end else if (idx_b_ff == rtdtc_pkg::IDX_W'(rtdtc_pkg::TABLE_POINTS)) begin
         side_c_in.direct = 1'b1;
         side_c_in.base   = rtdtc_pkg::TAB_CENTI[rtdtc_pkg::TABLE_POINTS-1];
      end else begin
         side_c_in.direct = 1'b0;
         side_c_in.base   = lo_centi;
      end

      if (side_c_in.lin) begin
         num_c_in = lin_num;
         den_c_in = rtdtc_pkg::LIN_DIV;
      end else begin
         num_c_in = tab_num;
         den_c_in = {den16, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      side_c_ff <= side_c_in;
      num_c_ff  <= num_c_in;
      den_c_ff  <= den_c_in;
   end

   // ---------------------------------------------------------------
   // interpolation / line divider
   // ---------------------------------------------------------------
   logic                        valid_q2;
   logic [rtdtc_pkg::Q2_W-1:0]  quo_q2;
   logic [SB2_W-1:0]            sb_q2;
   rtdtc_pkg::side_type         side_q2;

   rtdtc_div #(
      .NUM_W (rtdtc_pkg::N2_W),
      .DEN_W (rtdtc_pkg::D2_W),
      .QUO_W (rtdtc_pkg::Q2_W),
      .SB_W  (SB2_W)
   ) u_interp_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_c_ff),
      .in_num    (num_c_ff),
      .in_den    (den_c_ff),
      .in_sb     (side_c_ff),
      .out_valid (valid_q2),
      .out_quo   (quo_q2),
      .out_sb    (sb_q2)
   );

   assign side_q2 = rtdtc_pkg::side_type'(sb_q2);

   // ---------------------------------------------------------------
   // stage d: final temperature and output word register
   // ---------------------------------------------------------------
   logic signed [15:0] temp_d_in;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_temp_ff;
   logic [2:0]         rsp_status_ff;

   always_comb begin
      if (side_q2.status != rtdtc_pkg::ST_OK) begin
         temp_d_in = rtdtc_pkg::ERR_TEMP;
      end else if (side_q2.lin) begin
         if (side_q2.neg) begin
            temp_d_in = -$signed(quo_q2);
         end else if (quo_q2 > rtdtc_pkg::TEMP_MAX) begin
            temp_d_in = rtdtc_pkg::TEMP_MAX;
         end else begin
            temp_d_in = $signed(quo_q2);
         end
      end else if (side_q2.direct) begin
         temp_d_in = side_q2.base;
      end else begin
         temp_d_in = side_q2.base + $signed(quo_q2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_q2;
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff   <= temp_d_in;
      rsp_status_ff <= side_q2.status;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_status            = rsp_status_ff;

   // terms for the checks below
   logic rsp_err, rsp_table_ok, temp_in_span;

   assign rsp_err      = rsp_valid && rsp_status != rtdtc_pkg::ST_OK;
   assign rsp_table_ok = rsp_valid && rsp_status == rtdtc_pkg::ST_OK &&
                         conv_mode_ff == rtdtc_pkg::CONV_TABLE;
   assign temp_in_span = rsp_temperature_centi >= -16'sd2000 &&
                         rsp_temperature_centi <= 16'sd16000;

   // every error reports the fixed error temperature
   `RTD_ASSERT_IMPL(a_err_temp, rsp_err, rsp_temperature_centi == rtdtc_pkg::ERR_TEMP)
   // table mode stays between the table's end points
   `RTD_ASSERT_IMPL(a_table_span, rsp_table_ok, temp_in_span)
   // an accepted word enters the pipeline
   `RTD_ASSERT_NEXT(a_enter, start && !busy, valid_a_ff)

endmodule

[tb/tb_rtd_divider_temperature_convert.sv]
// testbench of the pt1000 divider temperature converter: directed table, then random words
module tb_rtd_divider_temperature_convert;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 52;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS = 450;
   localparam logic [11:0] ADC_FULL = 12'hFFF;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [11:0] req_adc_raw;
   logic rsp_valid;
   logic signed [15:0] rsp_temperature_centi;
   logic [2:0] rsp_status;
   logic csr_we;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;

   rtd_divider_temperature_convert DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_adc_raw(req_adc_raw), .rsp_valid(rsp_valid),
      .rsp_temperature_centi(rsp_temperature_centi), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic signed [15:0]    temp;
      rtdtc_pkg::status_type status;
   } reading_type;

   // shadow copy of the register file
   logic [15:0] ref_ohms, ref_min, ref_max, sens_min, sens_max;
   logic [1:0]  div_mode, conv_mode;

   reading_type pending_readings[$];
   int mismatch_count;
   int idle_cycles;
   bit timed_out;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // table interpolation on resistance in 1/16 ohm
   function automatic logic signed [15:0] interpolate_table(longint unsigned r16);
      int i;
      longint unsigned lo, den, dt, q;
      for (i = 0; i < rtdtc_pkg::TABLE_POINTS; i++)
         if (longint'(rtdtc_pkg::TAB_OHMS[i]) * 16 > r16) break;
      if (i == 0) return rtdtc_pkg::TAB_CENTI[0];
      if (i >= rtdtc_pkg::TABLE_POINTS) return rtdtc_pkg::TAB_CENTI[rtdtc_pkg::TABLE_POINTS-1];
      lo = longint'(rtdtc_pkg::TAB_OHMS[i-1]) * 16;
      den = longint'(rtdtc_pkg::TAB_OHMS[i] - rtdtc_pkg::TAB_OHMS[i-1]) * 16;
      dt = longint'(rtdtc_pkg::TAB_CENTI[i]) - longint'(rtdtc_pkg::TAB_CENTI[i-1]);
      q = (dt * (r16 - lo) * 2 + den) / (den * 2);
      return clip16(longint'(rtdtc_pkg::TAB_CENTI[i-1]) + longint'(q));
   endfunction

   // (R - 1000) / 3.8, halves away from zero
   function automatic logic signed [15:0] linear_temperature(longint unsigned r16);
      longint unsigned mag;
      if (r16 >= 16000) begin
         mag = ((r16 - 16000) * 250 + 76) / 152;
         if (mag > 40000) mag = 40000;
         return clip16(longint'(mag));
      end
      mag = ((16000 - r16) * 250 + 76) / 152;
      return clip16(-longint'(mag));
   endfunction

   function automatic reading_type predict_reading(logic [11:0] adc);
      reading_type res;
      longint unsigned r16, a, fs;
      a = adc;
      fs = ADC_FULL;
      res.temp = rtdtc_pkg::ERR_TEMP;
      res.status = rtdtc_pkg::ST_OK;
      if (ref_ohms < ref_min || ref_ohms > ref_max) res.status = rtdtc_pkg::ST_REF_RANGE;
      else if (div_mode == rtdtc_pkg::DIV_PULL_DOWN) begin
         if (a <= 10) res.status = rtdtc_pkg::ST_ADC_LOW;
      end else if (div_mode == rtdtc_pkg::DIV_PULL_UP) begin
         if (a >= fs - 10) res.status = rtdtc_pkg::ST_ADC_HIGH;
      end else res.status = rtdtc_pkg::ST_DIV_MODE;
      if (res.status == rtdtc_pkg::ST_OK) begin
         if (div_mode == rtdtc_pkg::DIV_PULL_DOWN)
            r16 = (longint'(ref_ohms) * (fs - a) * 16) / a;
         else r16 = (longint'(ref_ohms) * a * 16) / (fs - a);
         if (r16 < longint'(sens_min) * 16) res.status = rtdtc_pkg::ST_UNDER;
         else if (r16 > longint'(sens_max) * 16) res.status = rtdtc_pkg::ST_OVER;
         else if (conv_mode == rtdtc_pkg::CONV_TABLE) res.temp = interpolate_table(r16);
         else if (conv_mode == rtdtc_pkg::CONV_LINEAR) res.temp = linear_temperature(r16);
         else res.status = rtdtc_pkg::ST_CONV_MODE;
      end
      return res;
   endfunction

   // result checker, sampled at each edge with rsp_valid high outside reset
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word temp=%0d status=%0d",
                        rsp_temperature_centi, rsp_status);
         end else begin
            reading_type exp_r;
            exp_r = pending_readings.pop_front();
            if (rsp_temperature_centi !== exp_r.temp || rsp_status !== exp_r.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected temp=%0d status=%0d, got temp=%0d status=%0d",
                           exp_r.temp, exp_r.status, rsp_temperature_centi, rsp_status);
            end
         end
      end
   end

   // watchdog on cycles without any accepted word or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("TEST FAILED");
         $finish;
      end
   end

   // one write, then csr_we is dropped before returning so back to back writes never collide
   task automatic write_reg(logic [2:0] index, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         rtdtc_pkg::REG_REF_OHMS:  ref_ohms = value;
         rtdtc_pkg::REG_DIV_MODE:  div_mode = value[1:0];
         rtdtc_pkg::REG_CONV_MODE: conv_mode = value[1:0];
         rtdtc_pkg::REG_REF_MIN:   ref_min = value;
         rtdtc_pkg::REG_REF_MAX:   ref_max = value;
         rtdtc_pkg::REG_SENS_MIN:  sens_min = value;
         rtdtc_pkg::REG_SENS_MAX:  sens_max = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // send one word; gap drawn first, start held only while needed
   task automatic send_reading(logic [11:0] adc, bit typed, reading_type typed_r);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_adc_raw <= adc;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_readings.push_back(typed ? typed_r : predict_reading(adc));
   endtask

   // wait until every result is back, then let the pipe drain
   task automatic drain_pipe();
      start <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic restore_defaults();
      write_reg(rtdtc_pkg::REG_REF_OHMS, 16'd1000);
      write_reg(rtdtc_pkg::REG_DIV_MODE, 16'(rtdtc_pkg::DIV_PULL_DOWN));
      write_reg(rtdtc_pkg::REG_CONV_MODE, 16'(rtdtc_pkg::CONV_TABLE));
      write_reg(rtdtc_pkg::REG_REF_MIN, 16'd100);
      write_reg(rtdtc_pkg::REG_REF_MAX, 16'd65535);
      write_reg(rtdtc_pkg::REG_SENS_MIN, 16'd800);
      write_reg(rtdtc_pkg::REG_SENS_MAX, 16'd1700);
   endtask

   typedef struct {
      logic [2:0]  index;   // register written before the word when do_write is set
      bit          do_write;
      logic [15:0] value;
      logic [11:0] adc;
      bit          typed;
      reading_type result;
   } step_type;

   localparam reading_type NO_RESULT = '{temp: 16'sd0, status: rtdtc_pkg::ST_OK};
   localparam reading_type ERR_ADC_LOW = '{rtdtc_pkg::ERR_TEMP, rtdtc_pkg::ST_ADC_LOW};
   localparam reading_type ERR_ADC_HIGH = '{rtdtc_pkg::ERR_TEMP, rtdtc_pkg::ST_ADC_HIGH};
   localparam reading_type ERR_OVER = '{rtdtc_pkg::ERR_TEMP, rtdtc_pkg::ST_OVER};
   localparam reading_type ERR_UNDER = '{rtdtc_pkg::ERR_TEMP, rtdtc_pkg::ST_UNDER};
   localparam reading_type ERR_CONV = '{rtdtc_pkg::ERR_TEMP, rtdtc_pkg::ST_CONV_MODE};
   localparam reading_type ERR_DIV = '{rtdtc_pkg::ERR_TEMP, rtdtc_pkg::ST_DIV_MODE};
   localparam reading_type ERR_REF = '{rtdtc_pkg::ERR_TEMP, rtdtc_pkg::ST_REF_RANGE};

   localparam logic [2:0] R_OHMS = rtdtc_pkg::REG_REF_OHMS;
   localparam logic [2:0] R_DIV  = rtdtc_pkg::REG_DIV_MODE;
   localparam logic [2:0] R_CONV = rtdtc_pkg::REG_CONV_MODE;
   localparam logic [2:0] R_RMIN = rtdtc_pkg::REG_REF_MIN;
   localparam logic [2:0] R_RMAX = rtdtc_pkg::REG_REF_MAX;
   localparam logic [2:0] R_SMIN = rtdtc_pkg::REG_SENS_MIN;
   localparam logic [2:0] R_SMAX = rtdtc_pkg::REG_SENS_MAX;

   // directed rows; the pipeline is drained before each register write
   step_type directed_steps[] = '{
      '{R_OHMS, 0, 16'd0, 12'd2048, 0, NO_RESULT},                  // near 1000 ohm
      '{R_OHMS, 0, 16'd0, 12'd0, 1, ERR_ADC_LOW},
      '{R_OHMS, 0, 16'd0, 12'd10, 1, ERR_ADC_LOW},
      '{R_OHMS, 0, 16'd0, 12'd11, 1, ERR_OVER},
      '{R_OHMS, 0, 16'd0, ADC_FULL, 1, ERR_UNDER},
      '{R_OHMS, 0, 16'd0, 12'd2200, 0, NO_RESULT},                  // table low end
      '{R_OHMS, 0, 16'd0, 12'd1600, 0, NO_RESULT},                  // table high end
      '{R_OHMS, 0, 16'd0, 12'd1900, 0, NO_RESULT},
      '{R_SMIN, 1, 16'd0, 12'd2150, 0, NO_RESULT},                  // below 924 ohm
      '{R_SMAX, 1, 16'd65535, 12'd1500, 0, NO_RESULT},              // above 1609 ohm
      '{R_CONV, 1, 16'(rtdtc_pkg::CONV_LINEAR), 12'd2048, 0, NO_RESULT},
      '{R_CONV, 0, 16'd0, 12'd200, 0, NO_RESULT},                   // linear saturates
      '{R_CONV, 0, 16'd0, 12'd4000, 0, NO_RESULT},                  // linear negative
      '{R_CONV, 1, 16'd2, 12'd2048, 1, ERR_CONV},
      '{R_CONV, 1, 16'd3, 12'd2048, 1, ERR_CONV},
      '{R_DIV, 1, 16'(rtdtc_pkg::DIV_PULL_UP), 12'd2048, 0, NO_RESULT},
      '{R_DIV, 0, 16'd0, 12'd4085, 1, ERR_ADC_HIGH},
      '{R_DIV, 0, 16'd0, 12'd4084, 0, NO_RESULT},
      '{R_DIV, 0, 16'd0, 12'd0, 0, NO_RESULT},
      '{R_DIV, 1, 16'd2, 12'd2048, 1, ERR_DIV},
      '{R_DIV, 1, 16'd3, 12'd0, 1, ERR_DIV},
      '{R_RMIN, 1, 16'd2000, 12'd2048, 1, ERR_REF},
      '{R_RMAX, 1, 16'd999, 12'd0, 1, ERR_REF},
      '{R_OHMS, 1, 16'd65535, 12'd2048, 1, ERR_REF},
      '{R_OHMS, 1, 16'd1, 12'd2048, 1, ERR_REF}
   };

   // one random setting: mostly valid pull-down or pull-up with sane limits
   task automatic random_setting();
      write_reg(R_OHMS, ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                16'($urandom_range(500, 4000)));
      write_reg(R_DIV, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(2, 3)) :
                16'($urandom_range(0, 1)));
      write_reg(R_CONV, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(2, 3)) :
                16'($urandom_range(0, 1)));
      write_reg(R_RMIN, ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                16'($urandom_range(0, 400)));
      write_reg(R_RMAX, ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                16'($urandom_range(4000, 65535)));
      write_reg(R_SMIN, ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                16'($urandom_range(0, 900)));
      write_reg(R_SMAX, ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                16'($urandom_range(1650, 65535)));
   endtask

   initial begin
      logic [11:0] adc;
      reset = 1'b1;
      start = 1'b0;
      req_adc_raw = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      ref_ohms = 16'd1000;
      div_mode = rtdtc_pkg::DIV_PULL_DOWN;
      conv_mode = rtdtc_pkg::CONV_TABLE;
      ref_min = 16'd100; ref_max = 16'd65535; sens_min = 16'd800; sens_max = 16'd1700;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_steps[k]) begin
         if (directed_steps[k].do_write) begin
            drain_pipe();
            write_reg(directed_steps[k].index, directed_steps[k].value);
         end
         send_reading(directed_steps[k].adc, directed_steps[k].typed,
                      directed_steps[k].result);
      end
      drain_pipe();
      restore_defaults();

      // random part in phases of random settings
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 50 == 49) begin
            drain_pipe();
            random_setting();
         end
         case ($urandom_range(0, 9))
            0: adc = 12'($urandom_range(0, 12));
            1: adc = 12'($urandom_range(4082, 4095));
            2, 3: adc = 12'($urandom);
            default: adc = 12'($urandom_range(1500, 2300));  // near the pt1000 span
         endcase
         send_reading(adc, 0, NO_RESULT);
      end
      drain_pipe();

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // leftover expectations at the end are caught by drain_pipe never returning,
   // which the watchdog turns into a failure
endmodule
